FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define BCLW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is checked also while reset is high.
`define BCLW_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/bclw_pkg.sv
// ---------------------------------------------------------------------------
// bclw_pkg
// Types, constants and codes of the write-back block cache controller.
// ---------------------------------------------------------------------------
package bclw_pkg;

   // Geometry of the cache and of the device.
   localparam int CACHE_ENTRIES  = 16;
   localparam int ENTRY_IDX_W    = $clog2(CACHE_ENTRIES);
   localparam int DEVICE_BLOCKS  = 65536;
   localparam int BLOCK_W        = 16;
   localparam int USE_COUNT_BITS = 16;
   localparam logic [USE_COUNT_BITS-1:0] USE_MAX = {USE_COUNT_BITS{1'b1}};

   // Field widths of the words on the ports.
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   // The first-access bitmap is kept as rows of MAP_ROW_W bits.
   localparam int MAP_ROW_W     = 32;
   localparam int MAP_BIT_W     = $clog2(MAP_ROW_W);
   localparam int MAP_ROWS      = DEVICE_BLOCKS / MAP_ROW_W;
   localparam int MAP_ROW_IDX_W = $clog2(MAP_ROWS);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FLUSH = 2'd3;

   // One entry of the tag memory.
   typedef struct packed {
      logic                      valid;
      logic                      dirty;
      logic [BLOCK_W-1:0]        tag;
      logic [USE_COUNT_BITS-1:0] count;
   } entry_type;

   // Entries streamed from the tag memory into the selection unit.
   typedef struct packed {
      logic                   start;
      logic                   valid;
      logic [ENTRY_IDX_W-1:0] idx;
      logic [BLOCK_W-1:0]     blk;
      entry_type              entry;
   } scan_type;

   // Hit and replacement choice after a full scan.
   typedef struct packed {
      logic                   hit;
      logic [ENTRY_IDX_W-1:0] hit_idx;
      entry_type              hit_entry;
      logic                   clean_found;
      logic [ENTRY_IDX_W-1:0] clean_idx;
      logic [ENTRY_IDX_W-1:0] all_idx;
      logic [BLOCK_W-1:0]     all_tag;
   } victim_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_CHK,
      ST_ZERO,
      ST_SCAN,
      ST_UPDATE,
      ST_FL_SCAN,
      ST_FL_RD,
      ST_FL_CHK
   } state_type;

endpackage

FILE: rtl/bclw_victim.sv
// ---------------------------------------------------------------------------
// bclw_victim
// Accumulates the hit entry and the replacement candidates over a scan.
// ---------------------------------------------------------------------------
module bclw_victim
   import bclw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  scan_type   scan_i,
   output victim_type sel_o
);

   logic                      hit_ff, hit_in;
   logic [ENTRY_IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   entry_type                 hit_entry_ff, hit_entry_in;
   logic                      clean_found_ff, clean_found_in;
   logic [ENTRY_IDX_W-1:0]    clean_idx_ff, clean_idx_in;
   logic [USE_COUNT_BITS-1:0] clean_cnt_ff, clean_cnt_in;
   logic [ENTRY_IDX_W-1:0]    all_idx_ff, all_idx_in;
   logic [USE_COUNT_BITS-1:0] all_cnt_ff, all_cnt_in;
   logic [BLOCK_W-1:0]        all_tag_ff, all_tag_in;

   // Compare the incoming entry against the best ones seen so far.
   always_comb begin
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      clean_found_in = clean_found_ff;
      clean_idx_in   = clean_idx_ff;
      clean_cnt_in   = clean_cnt_ff;
      all_idx_in     = all_idx_ff;
      all_cnt_in     = all_cnt_ff;
      all_tag_in     = all_tag_ff;
      if (scan_i.start) begin
         hit_in         = 1'b0;
         clean_found_in = 1'b0;
      end else if (scan_i.valid) begin
         // The first valid entry with a matching tag is the hit.
         if (!hit_ff && scan_i.entry.valid && (scan_i.entry.tag == scan_i.blk)) begin
            hit_in       = 1'b1;
            hit_idx_in   = scan_i.idx;
            hit_entry_in = scan_i.entry;
         end
         // Lowest use count among clean entries; a strict compare keeps the
         // lowest index on a tie.
         if (!scan_i.entry.dirty &&
             (!clean_found_ff || (clean_cnt_ff > scan_i.entry.count))) begin
            clean_found_in = 1'b1;
            clean_idx_in   = scan_i.idx;
            clean_cnt_in   = scan_i.entry.count;
         end
         // Lowest use count over all entries, starting from entry zero.
         if ((scan_i.idx == '0) || (all_cnt_ff > scan_i.entry.count)) begin
            all_idx_in = scan_i.idx;
            all_cnt_in = scan_i.entry.count;
            all_tag_in = scan_i.entry.tag;
         end
      end
   end

   // Found flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff         <= 1'b0;
         clean_found_ff <= 1'b0;
      end else begin
         hit_ff         <= hit_in;
         clean_found_ff <= clean_found_in;
      end
   end

   // Candidate payload.
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      clean_idx_ff <= clean_idx_in;
      clean_cnt_ff <= clean_cnt_in;
      all_idx_ff   <= all_idx_in;
      all_cnt_ff   <= all_cnt_in;
      all_tag_ff   <= all_tag_in;
   end

   assign sel_o.hit         = hit_ff;
   assign sel_o.hit_idx     = hit_idx_ff;
   assign sel_o.hit_entry   = hit_entry_ff;
   assign sel_o.clean_found = clean_found_ff;
   assign sel_o.clean_idx   = clean_idx_ff;
   assign sel_o.all_idx     = all_idx_ff;
   assign sel_o.all_tag     = all_tag_ff;

endmodule

FILE: rtl/block_cache_lfu_writeback_top.sv
// ---------------------------------------------------------------------------
// block_cache_lfu_writeback_top
// Tag and replacement controller of a write-back block cache with LFU choice.
// ---------------------------------------------------------------------------
// A read or write passes from acceptance through the bitmap read-modify-write,
// then the one-entry-a-cycle scan of the tag memory, then the update. A read of
// a block not seen before skips the scan and gives a zero-block result. A flush
// scans the tag memory, then reads and checks each entry up to the last dirty one.
// One request is in flight at a time.
// After reset a clearing pass zeroes both memories.
module block_cache_lfu_writeback_top
   import bclw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [BLOCK_W-1:0]  req_block_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_fetch_needed,
   output logic                rsp_writeback_valid,
   output logic [BLOCK_W-1:0]  rsp_writeback_block,
   output logic                rsp_last
);

   // Memories.
   logic [MAP_ROW_W-1:0] map_mem [MAP_ROWS];
   entry_type            ent_mem [CACHE_ENTRIES];

   state_type                state_ff, state_in;
   logic [MAP_ROW_IDX_W-1:0] clr_ff, clr_in;
   logic [ENTRY_IDX_W:0]     idx_ff, idx_in;
   logic [CACHE_ENTRIES-1:0] dmask_ff, dmask_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [BLOCK_W-1:0]       blk_ff, blk_in;

   // Memory ports.
   logic                     map_rd_en;
   logic                     map_wr_en;
   logic [MAP_ROW_IDX_W-1:0] map_wr_addr;
   logic [MAP_ROW_W-1:0]     map_wdata;
   logic [MAP_ROW_W-1:0]     map_q_ff;
   logic                     ent_rd_en;
   logic [ENTRY_IDX_W-1:0]   ent_rd_addr;
   logic                     ent_wr_en;
   logic [ENTRY_IDX_W-1:0]   ent_wr_addr;
   entry_type                ent_wdata;
   entry_type                ent_q_ff;
   logic                     ent_qv_ff;
   logic [ENTRY_IDX_W-1:0]   ent_qidx_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                emit;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                fetch_ff, fetch_in;
   logic                wbv_ff, wbv_in;
   logic [BLOCK_W-1:0]  wbb_ff, wbb_in;
   logic                last_ff, last_in;

   scan_type   scan;
   logic       scan_start;
   victim_type sel;

   // Shared conditions.
   logic                     accept;
   logic                     out_free;
   logic                     seen_now;
   logic                     scan_done;
   logic [CACHE_ENTRIES-1:0] scan_mask;
   logic [CACHE_ENTRIES-1:0] fl_bit;
   logic                     fl_dirty;
   logic                     fl_last;
   logic [ENTRY_IDX_W-1:0]   vict_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign seen_now  = map_q_ff[blk_ff[MAP_BIT_W-1:0]];
   assign scan_done = ent_qv_ff && (ent_qidx_ff == ENTRY_IDX_W'(CACHE_ENTRIES - 1));
   assign fl_bit    = CACHE_ENTRIES'(1) << idx_ff[ENTRY_IDX_W-1:0];
   assign fl_dirty  = (dmask_ff & fl_bit) != '0;
   assign fl_last   = (dmask_ff & ~fl_bit) == '0;
   assign vict_idx  = sel.clean_found ? sel.clean_idx : sel.all_idx;

   // Dirty mask as it stands once the current flush scan entry is counted.
   always_comb begin
      scan_mask = dmask_ff;
      if (ent_qv_ff && ent_q_ff.dirty) begin
         scan_mask = dmask_ff | (CACHE_ENTRIES'(1) << ent_qidx_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == MAP_ROW_IDX_W'(MAP_ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind) inside
                  KIND_READ, KIND_WRITE: state_in = ST_MAP_RD;
                  KIND_FLUSH:            state_in = ST_FL_SCAN;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAP_RD:  state_in = ST_MAP_CHK;
         ST_MAP_CHK: begin
            if ((kind_ff == KIND_READ) && !seen_now) state_in = ST_ZERO;
            else                                     state_in = ST_SCAN;
         end
         ST_ZERO: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_FL_SCAN: begin
            if (scan_done) state_in = (scan_mask != '0) ? ST_FL_RD : ST_IDLE;
         end
         ST_FL_RD: state_in = ST_FL_CHK;
         ST_FL_CHK: begin
            if (!fl_dirty)     state_in = ST_FL_RD;
            else if (out_free) state_in = fl_last ? ST_IDLE : ST_FL_RD;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the sequencer: memory ports, counters and the result word.
   always_comb begin
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      dmask_in    = dmask_ff;
      kind_in     = kind_ff;
      blk_in      = blk_ff;
      map_rd_en   = 1'b0;
      map_wr_en   = 1'b0;
      map_wr_addr = blk_ff[BLOCK_W-1:MAP_BIT_W];
      map_wdata   = map_q_ff | (MAP_ROW_W'(1) << blk_ff[MAP_BIT_W-1:0]);
      ent_rd_en   = 1'b0;
      ent_rd_addr = idx_ff[ENTRY_IDX_W-1:0];
      ent_wr_en   = 1'b0;
      ent_wr_addr = ent_qidx_ff;
      ent_wdata   = ent_q_ff;
      scan_start  = 1'b0;
      emit        = 1'b0;
      status_in   = status_ff;
      slot_in     = slot_ff;
      fetch_in    = fetch_ff;
      wbv_in      = wbv_ff;
      wbb_in      = wbb_ff;
      last_in     = last_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one bitmap row and one tag entry per cycle.
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            map_wdata   = '0;
            ent_wr_en   = 1'b1;
            ent_wr_addr = clr_ff[ENTRY_IDX_W-1:0];
            ent_wdata   = '0;
            clr_in      = clr_ff + MAP_ROW_IDX_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               blk_in   = req_block_number;
               idx_in   = '0;
               dmask_in = '0;
            end
         end
         ST_MAP_RD: begin
            map_rd_en = 1'b1;
         end
         ST_MAP_CHK: begin
            // Set the first-access bit and restart the selection unit.
            map_wr_en  = 1'b1;
            scan_start = 1'b1;
         end
         ST_ZERO: begin
            if (out_free) begin
               emit      = 1'b1;
               status_in = STATUS_ZERO;
               slot_in   = '0;
               fetch_in  = 1'b0;
               wbv_in    = 1'b0;
               wbb_in    = '0;
               last_in   = 1'b1;
            end
         end
         ST_SCAN, ST_FL_SCAN: begin
            // Issue one read per cycle until every entry has been requested.
            if (idx_ff < (ENTRY_IDX_W + 1)'(CACHE_ENTRIES)) begin
               ent_rd_en = 1'b1;
               idx_in    = idx_ff + (ENTRY_IDX_W + 1)'(1);
            end
            if (state_ff == ST_FL_SCAN) begin
               dmask_in = scan_mask;
               if (scan_done) idx_in = '0;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               emit      = 1'b1;
               ent_wr_en = 1'b1;
               last_in   = 1'b1;
               if (sel.hit) begin
                  // Hit: a read bumps the saturating count, a write marks dirty.
                  ent_wr_addr = sel.hit_idx;
                  ent_wdata   = sel.hit_entry;
                  if (kind_ff == KIND_READ) begin
                     if (sel.hit_entry.count != USE_MAX) begin
                        ent_wdata.count = sel.hit_entry.count + USE_COUNT_BITS'(1);
                     end
                  end else begin
                     ent_wdata.dirty = 1'b1;
                  end
                  status_in = STATUS_HIT;
                  slot_in   = SLOT_W'(sel.hit_idx);
                  fetch_in  = 1'b0;
                  wbv_in    = 1'b0;
                  wbb_in    = '0;
               end else begin
                  // Miss: fill the victim, evicting it when no entry is clean.
                  ent_wr_addr     = vict_idx;
                  ent_wdata.valid = 1'b1;
                  ent_wdata.dirty = (kind_ff == KIND_WRITE);
                  ent_wdata.tag   = blk_ff;
                  ent_wdata.count = (kind_ff == KIND_WRITE) ? USE_COUNT_BITS'(1) : '0;
                  status_in       = STATUS_MISS;
                  slot_in         = SLOT_W'(vict_idx);
                  fetch_in        = (kind_ff == KIND_READ);
                  wbv_in          = !sel.clean_found;
                  wbb_in          = sel.clean_found ? '0 : sel.all_tag;
               end
            end
         end
         ST_FL_RD: begin
            ent_rd_en = 1'b1;
         end
         ST_FL_CHK: begin
            if (!fl_dirty) begin
               idx_in = idx_ff + (ENTRY_IDX_W + 1)'(1);
            end else if (out_free) begin
               // Write back this dirty entry and mark it clean.
               emit            = 1'b1;
               ent_wr_en       = 1'b1;
               ent_wdata.dirty = 1'b0;
               dmask_in        = dmask_ff & ~fl_bit;
               idx_in          = idx_ff + (ENTRY_IDX_W + 1)'(1);
               status_in       = STATUS_FLUSH;
               slot_in         = SLOT_W'(ent_qidx_ff);
               fetch_in        = 1'b0;
               wbv_in          = 1'b1;
               wbb_in          = ent_q_ff.tag;
               last_in         = fl_last;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   // The result word stays until the consumer takes it.
   always_comb begin
      if (emit)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         dmask_ff     <= '0;
         ent_qv_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         dmask_ff     <= dmask_in;
         ent_qv_ff    <= ent_rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload.
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      blk_ff    <= blk_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fetch_ff  <= fetch_in;
      wbv_ff    <= wbv_in;
      wbb_ff    <= wbb_in;
      last_ff   <= last_in;
   end

   // First-access bitmap memory.
   always_ff @(posedge clock) begin
      if (map_wr_en) map_mem[map_wr_addr] <= map_wdata;
      if (map_rd_en) map_q_ff <= map_mem[blk_ff[BLOCK_W-1:MAP_BIT_W]];
   end

   // Tag memory.
   always_ff @(posedge clock) begin
      if (ent_wr_en) ent_mem[ent_wr_addr] <= ent_wdata;
      if (ent_rd_en) begin
         ent_q_ff    <= ent_mem[ent_rd_addr];
         ent_qidx_ff <= ent_rd_addr;
      end
   end

   // Stream of scanned entries into the selection unit.
   assign scan.start = scan_start;
   assign scan.valid = ent_qv_ff && (state_ff == ST_SCAN);
   assign scan.idx   = ent_qidx_ff;
   assign scan.blk   = blk_ff;
   assign scan.entry = ent_q_ff;

   bclw_victim u_victim (
      .clock  (clock),
      .reset  (reset),
      .scan_i (scan),
      .sel_o  (sel)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_fetch_needed    = fetch_ff;
   assign rsp_writeback_valid = wbv_ff;
   assign rsp_writeback_block = wbb_ff;
   assign rsp_last            = last_ff;

endmodule

FILE: rtl/bclw_checker.sv
// ---------------------------------------------------------------------------
// bclw_checker
// Port-level checks of the block cache controller, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bclw_checker
   import bclw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [KIND_W-1:0]   req_kind,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic                rsp_fetch_needed,
   input logic                rsp_writeback_valid,
   input logic [BLOCK_W-1:0]  rsp_writeback_block,
   input logic                rsp_last
);

   // No result word is offered right after reset.
   `BCLW_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid, "result word after reset")

   // A stalled result word holds.
   `BCLW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_writeback_block) && $stable(rsp_last), "stalled result word changed")

   // A read or write keeps the input closed while it works.
   `BCLW_ASSERT(a_busy, clock, reset, req_valid && req_ready && (req_kind == KIND_READ || req_kind == KIND_WRITE) |=> !req_ready, "request taken while busy")

   // A zero-block word carries nothing but its status and the last mark.
   `BCLW_ASSERT(a_zero_fields, clock, reset, rsp_valid && (rsp_status == STATUS_ZERO) |-> (rsp_slot == '0) && !rsp_fetch_needed && !rsp_writeback_valid && (rsp_writeback_block == '0) && rsp_last, "zero-block word has stray fields")

   // Without a write-back the block field reads zero.
   `BCLW_ASSERT(a_wb_zero, clock, reset, rsp_valid && !rsp_writeback_valid |-> rsp_writeback_block == '0, "write-back block without write-back")

endmodule

bind block_cache_lfu_writeback_top bclw_checker u_checker (.*);
